// ===== rtl/direct_mapped_move_book_assert.svh =====
// assertion macros for the move book, clocked on clk_i and held off during rst_ni
`ifndef DIRECT_MAPPED_MOVE_BOOK_ASSERT_SVH
`define DIRECT_MAPPED_MOVE_BOOK_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DMMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DMMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmmb_pkg.sv =====
// shared types and constants of the move book
package dmmb_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned MOVE_IN_W   = 16;
  localparam int unsigned MOVE_OUT_W  = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_OUT_W = 3;

  typedef enum logic {
    OP_PROBE = 1'b0,
    OP_STORE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_MISS   = 3'd1,
    ST_STORED = 3'd2,
    ST_DUP    = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CNT_ZERO = 2'd0,
    CNT_OLD  = 2'd1,
    CNT_NEW  = 2'd2
  } cnt_sel_e;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_DECIDE = 3'd2,
    S_STREAM = 3'd3,
    S_SCAN   = 3'd4
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     clr_step;
    logic     ent_wr;
    logic     ent_inc;
    logic     mv_wr;
    logic     rd_first;
    logic     rd_next;
    logic     emit;
    status_e  emit_status;
    logic     emit_move;
    cnt_sel_e emit_cnt;
    logic     emit_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic tag_hit;
    logic cnt_zero;
    logic cnt_full;
    logic slot_last;
    logic mv_match;
    op_e  op;
  } sts_t;

endpackage

// ===== rtl/dmmb_ctrl.sv =====
// controller state machine of the move book
module dmmb_ctrl import dmmb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_status = ST_HIT;
    cmd_o.emit_cnt    = CNT_ZERO;
    busy_o  = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.op == OP_PROBE) begin
          if (!sts_i.tag_hit) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_MISS;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_IDLE;
          end else if (sts_i.cnt_zero) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_HIT;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.rd_first = 1'b1;
            state_d        = S_STREAM;
          end
        end else begin
          cmd_o.ent_wr = 1'b1;
          if (sts_i.cnt_full) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_FULL;
            cmd_o.emit_cnt    = CNT_OLD;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_IDLE;
          end else if (sts_i.cnt_zero) begin
            cmd_o.ent_inc     = 1'b1;
            cmd_o.mv_wr       = 1'b1;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ST_STORED;
            cmd_o.emit_cnt    = CNT_NEW;
            cmd_o.emit_last   = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.rd_first = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_STREAM: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = ST_HIT;
        cmd_o.emit_move   = 1'b1;
        cmd_o.emit_cnt    = CNT_OLD;
        cmd_o.emit_last   = sts_i.slot_last;
        if (sts_i.slot_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts_i.mv_match) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_DUP;
          cmd_o.emit_cnt    = CNT_OLD;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else if (sts_i.slot_last) begin
          cmd_o.ent_wr      = 1'b1;
          cmd_o.ent_inc     = 1'b1;
          cmd_o.mv_wr       = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_STORED;
          cmd_o.emit_cnt    = CNT_NEW;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/dmmb_datapath.sv =====
// datapath of the move book: entry and move memories, compares, result register
module dmmb_datapath import dmmb_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned SLOTS       = 8,
  parameter int unsigned MOVE_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   op_i,
  input  logic [KEY_W-1:0]       key_i,
  input  logic [MOVE_IN_W-1:0]   move_in_i,
  output logic                   valid_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [MOVE_OUT_W-1:0]  move_out_o,
  output logic [COUNT_OUT_W-1:0] move_count_o,
  output logic                   last_o
);

  localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W    = $clog2(SLOTS);
  localparam int unsigned CW1      = CNT_W + 1;
  localparam int unsigned ENT_W    = KEY_W + CNT_W;
  localparam int unsigned MV_DEPTH = TABLE_DEPTH * (2 ** CNT_W);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SLOTS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic [ENT_W-1:0]     ent_mem [TABLE_DEPTH];
  logic [MOVE_BITS-1:0] mv_mem  [MV_DEPTH];

  op_e                  op_q;
  logic [KEY_W-1:0]     key_q;
  logic [MOVE_BITS-1:0] move_q;
  logic [ENT_W-1:0]     ent_rd_q;
  logic [MOVE_BITS-1:0] mv_rd_q;
  logic [CNT_W-1:0]     slot_q, slot_d;
  logic [IDX_W-1:0]     clr_q;

  logic                   valid_q;
  status_e                status_q;
  logic [MOVE_OUT_W-1:0]  move_out_q;
  logic [COUNT_OUT_W-1:0] count_out_q;
  logic                   last_q;

  logic [IDX_W-1:0] idx;
  logic [KEY_W-1:0] ent_tag;
  logic [CNT_W-1:0] ent_cnt, cnt_inc, cnt_wr, rd_slot;
  logic [31:0]      mv_wide, cnt_old_wide, cnt_new_wide;

  assign idx     = key_q[IDX_W-1:0];
  assign ent_tag = ent_rd_q[ENT_W-1:CNT_W];
  assign ent_cnt = ent_rd_q[CNT_W-1:0];
  assign cnt_inc = ent_cnt + CNT_W'(1);
  assign cnt_wr  = cmd_i.ent_inc ? cnt_inc : ent_cnt;
  assign rd_slot = cmd_i.rd_first ? '0 : slot_q + CNT_W'(1);
  assign slot_d  = (cmd_i.rd_first || cmd_i.rd_next) ? rd_slot : slot_q;

  assign mv_wide      = 32'(mv_rd_q);
  assign cnt_old_wide = 32'(ent_cnt);
  assign cnt_new_wide = 32'(cnt_inc);

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      key_q  <= key_i;
      move_q <= MOVE_BITS'(move_in_i);
    end
  end

  // tag and count per entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      ent_mem[clr_q] <= '0;
    end else if (cmd_i.ent_wr) begin
      ent_mem[idx] <= {key_q, cnt_wr};
    end
    if (cmd_i.load) begin
      ent_rd_q <= ent_mem[key_i[IDX_W-1:0]];
    end
  end

  // move slots, row per entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_wr) begin
      mv_mem[{idx, ent_cnt}] <= move_q;
    end
    if (cmd_i.rd_first || cmd_i.rd_next) begin
      mv_rd_q <= mv_mem[{idx, rd_slot}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + IDX_W'(1);
      slot_q  <= slot_d;
      valid_q <= cmd_i.emit;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q   <= cmd_i.emit_status;
      move_out_q <= cmd_i.emit_move ? mv_wide[MOVE_OUT_W-1:0] : '0;
      last_q     <= cmd_i.emit_last;
      case (cmd_i.emit_cnt)
        CNT_OLD: count_out_q <= cnt_old_wide[COUNT_OUT_W-1:0];
        CNT_NEW: count_out_q <= cnt_new_wide[COUNT_OUT_W-1:0];
        default: count_out_q <= '0;
      endcase
    end
  end

  always_comb begin
    sts_o.clr_done  = (clr_q == IDX_LAST);
    sts_o.tag_hit   = (ent_tag == key_q);
    sts_o.cnt_zero  = (ent_cnt == '0);
    sts_o.cnt_full  = (ent_cnt >= CNT_MAX);
    sts_o.slot_last = ((CW1'(slot_q) + CW1'(1)) == CW1'(ent_cnt));
    sts_o.mv_match  = (mv_rd_q == move_q);
    sts_o.op        = op_q;
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign move_out_o   = move_out_q;
  assign move_count_o = count_out_q;
  assign last_o       = last_q;

endmodule

// ===== rtl/direct_mapped_move_book.sv =====
// top level of the direct-mapped move book
// A direct-mapped book of moves keyed by a 64-bit position hash: the low
// log2(TABLE_DEPTH) key bits pick an entry, the whole key is its tag, and each
// entry holds a move count and up to SLOTS-1 moves. A transaction is taken when
// start is high and busy is low. After reset the block sweeps the tag/count
// memory clear, one entry a cycle, and busy stays high until the sweep ends.
// A probe miss, an empty hit, a store into a full entry and a store into an
// empty entry give their single result from the decide state; a probe hit
// reads its moves from the move memory one per cycle and streams them out
// one per cycle; a store that checks for duplicates compares one held move
// per cycle through the same read port, ending early on a match. Busy stays
// high until the last result is decided. Results come from a register in the
// cycle after they are decided, each for exactly one cycle with valid_o high,
// and last_o marks the final result of a transaction; the receiver cannot hold
// results off, so it must take every strobe as it comes.
`include "direct_mapped_move_book_assert.svh"

module direct_mapped_move_book import dmmb_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned SLOTS       = 8,
  parameter int unsigned MOVE_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op_i,
  input  logic [KEY_W-1:0]       key_i,
  input  logic [MOVE_IN_W-1:0]   move_in_i,
  output logic                   valid_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [MOVE_OUT_W-1:0]  move_out_o,
  output logic [COUNT_OUT_W-1:0] move_count_o,
  output logic                   last_o
);

  // command and status between the state machine and the datapath
  cmd_t cmd;
  sts_t sts;

  dmmb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  dmmb_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SLOTS       (SLOTS),
    .MOVE_BITS   (MOVE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op_i),
    .key_i        (key_i),
    .move_in_i    (move_in_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .move_out_o   (move_out_o),
    .move_count_o (move_count_o),
    .last_o       (last_o)
  );

  // an accepted transaction keeps the block busy in the next cycle
  `DMMB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")
  // a hit stream has no gaps between its results
  `DMMB_ASSERT_NEXT(a_stream_gapless, valid_o && !last_o, valid_o, "gap in hit stream")
  // the final result shows exactly when the block has gone idle
  `DMMB_ASSERT_NOW(a_last_idle, valid_o, last_o == !busy, "last marker and busy disagree")
  // no result while the memory is being cleared
  `DMMB_ASSERT_NOW(a_clear_quiet, cmd.clr_step, !valid_o, "result during clearing pass")

endmodule

// ===== test/tb.sv =====
// testbench for the direct-mapped move book: queued driver, strobe monitor, predicted results
module tb import dmmb_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned MOVE_BITS   = 16;
  localparam logic [MOVE_IN_W-1:0] MOVE_MASK = MOVE_IN_W'((64'd1 << MOVE_BITS) - 1);

  // items left in the queue when idling stops, so the run ends at full rate
  localparam int unsigned QUIET_TAIL   = 40;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned PHASES       = 3;
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned MAX_PRINTED  = 100;
  localparam int unsigned SETTLE_TIME  = 20;

  localparam logic [KEY_W-1:0] KEY_ONES  = '1;
  // same entry as KEY_ONES (low bits all one), different tag
  localparam logic [KEY_W-1:0] KEY_ALIAS = 64'h5555_5555_5555_57ff;

  // one transaction offered to the block
  typedef struct {
    op_e                  op;
    logic [KEY_W-1:0]     key;
    logic [MOVE_IN_W-1:0] mv;
    bit                   wait_drain; // hold this one back until nothing is due
  } book_cmd_t;

  // one result strobe as the block should give it
  typedef struct {
    status_e                status;
    logic [MOVE_OUT_W-1:0]  mv;
    logic [COUNT_OUT_W-1:0] cnt;
    logic                   last;
  } book_res_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  logic                   op_i      = 1'b0;
  logic [KEY_W-1:0]       key_i     = '0;
  logic [MOVE_IN_W-1:0]   move_in_i = '0;
  logic                   valid_o;
  logic [STATUS_W-1:0]    status_o;
  logic [MOVE_OUT_W-1:0]  move_out_o;
  logic [COUNT_OUT_W-1:0] move_count_o;
  logic                   last_o;

  // pending transactions and the results still owed by the block
  book_cmd_t cmd_q[$];
  book_res_t due_q[$];

  // private copy of the book: tags, move counts and move slots, zero after reset
  bit [KEY_W-1:0]     book_tag   [TABLE_DEPTH];
  bit [2:0]           book_cnt   [TABLE_DEPTH];
  bit [MOVE_IN_W-1:0] book_moves [TABLE_DEPTH][SLOTS];

  int unsigned n_errors = 0;
  int unsigned cycles   = 0;

  direct_mapped_move_book #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SLOTS       (SLOTS),
    .MOVE_BITS   (MOVE_BITS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .key_i        (key_i),
    .move_in_i    (move_in_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .move_out_o   (move_out_o),
    .move_count_o (move_count_o),
    .last_o       (last_o)
  );

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    // past the print cap mismatches are only counted
    if (n_errors < MAX_PRINTED) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
    n_errors++;
  endtask

  function automatic void due_result(status_e status, logic [MOVE_OUT_W-1:0] mv,
                                     int unsigned cnt, bit last);
    book_res_t r;
    r.status = status;
    r.mv     = mv;
    r.cnt    = COUNT_OUT_W'(cnt);
    r.last   = last;
    due_q.push_back(r);
  endfunction

  // works out the strobes one accepted transaction causes and updates the book copy
  function automatic void predict_book(book_cmd_t c);
    int unsigned          idx;
    int unsigned          n;
    bit                   seen;
    logic [MOVE_IN_W-1:0] mv;
    idx  = int'(c.key % TABLE_DEPTH);
    n    = book_cnt[idx];
    mv   = c.mv & MOVE_MASK;
    seen = 1'b0;
    if (n > SLOTS - 1) n = SLOTS - 1;
    if (c.op == OP_PROBE) begin
      if (book_tag[idx] != c.key) begin
        due_result(ST_MISS, '0, 0, 1'b1);
      end else if (n == 0) begin
        // tag matches but nothing held yet: one empty hit
        due_result(ST_HIT, '0, 0, 1'b1);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          due_result(ST_HIT, book_moves[idx][i], n, i + 1 == n);
        end
      end
    end else begin
      // the tag is taken over even when the old moves stay
      book_tag[idx] = c.key;
      if (n >= SLOTS - 1) begin
        due_result(ST_FULL, '0, n, 1'b1);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          if (book_moves[idx][i] == mv) seen = 1'b1;
        end
        if (seen) begin
          due_result(ST_DUP, '0, n, 1'b1);
        end else begin
          book_moves[idx][n] = mv;
          book_cnt[idx]      = 3'(n + 1);
          due_result(ST_STORED, '0, n + 1, 1'b1);
        end
      end
    end
  endfunction

  function automatic void add_cmd(op_e op, logic [KEY_W-1:0] key,
                                  logic [MOVE_IN_W-1:0] mv, bit wait_drain = 1'b0);
    book_cmd_t c;
    c.op         = op;
    c.key        = key;
    c.mv         = mv;
    c.wait_drain = wait_drain;
    cmd_q.push_back(c);
  endfunction

  // mostly small codes so duplicates turn up, with some wide and random ones
  function automatic logic [MOVE_IN_W-1:0] pick_move();
    case ($urandom_range(0, 3))
      0, 1:    pick_move = MOVE_IN_W'($urandom_range(0, 11));
      2:       pick_move = MOVE_IN_W'($urandom);
      default: pick_move = MOVE_IN_W'(16'hffff ^ $urandom_range(0, 11));
    endcase
  endfunction

  // driver: presents the head of cmd_q, holds it while busy, idles in bursts
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic        nstart;
    book_cmd_t   cur_cmd;
    int unsigned idle_left;
    if (!rst_ni) begin
      idle_left = 0;
      start     <= 1'b0;
    end else begin
      nstart = 1'b0;
      if (start && !busy) begin
        // transaction taken at this edge
        predict_book(cur_cmd);
        if (cmd_q.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, 18);
        end
      end
      if (start && busy) begin
        nstart = 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
      end else if (cmd_q.size() > 0 &&
                   (!cmd_q[0].wait_drain || (due_q.size() == 0 && !valid_o))) begin
        // valid_o low means the monitor leaves due_q alone at this edge
        cur_cmd   = cmd_q.pop_front();
        nstart    = 1'b1;
        op_i      <= cur_cmd.op;
        key_i     <= cur_cmd.key;
        move_in_i <= cur_cmd.mv;
      end
      start <= nstart;
    end
  end

  // monitor: every strobe is taken, so each one is matched against the oldest due result
  always @(posedge clk_i) begin : monitor
    book_res_t w;
    if (rst_ni && valid_o === 1'b1) begin
      if (due_q.size() == 0) begin
        report_mismatch("unexpected result, status", status_o, '0);
      end else begin
        w = due_q.pop_front();
        if (status_o !== w.status)     report_mismatch("status", status_o, w.status);
        if (move_out_o !== w.mv)       report_mismatch("move_out", move_out_o, w.mv);
        if (move_count_o !== w.cnt)    report_mismatch("move_count", move_count_o, w.cnt);
        if (last_o !== w.last)         report_mismatch("last", last_o, w.last);
      end
    end
  end

  // watchdog; its count also covers the clearing sweep after reset
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("** direct_mapped_move_book: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] pool_key [12];
    int unsigned      pool_idx [6];
    int unsigned      pick;
    logic [KEY_W-1:0] k;

    // directed: empty hit on the zero tag, a miss, stores, duplicate, full entry,
    // tag takeover that keeps the moves, and a probe of the displaced key
    add_cmd(OP_PROBE, '0, '0);
    add_cmd(OP_PROBE, KEY_ONES, 16'h1234);
    add_cmd(OP_STORE, KEY_ONES, 16'hffff);
    add_cmd(OP_STORE, KEY_ONES, 16'h0000);
    add_cmd(OP_STORE, KEY_ONES, 16'hffff);
    add_cmd(OP_PROBE, KEY_ONES, '0);
    add_cmd(OP_STORE, KEY_ONES, 16'h0001);
    add_cmd(OP_STORE, KEY_ONES, 16'h8000);
    add_cmd(OP_STORE, KEY_ONES, 16'h5555);
    add_cmd(OP_STORE, KEY_ONES, 16'haaaa);
    add_cmd(OP_STORE, KEY_ONES, 16'h00ff);
    add_cmd(OP_STORE, KEY_ONES, 16'h1234);
    add_cmd(OP_PROBE, KEY_ONES, '0);
    add_cmd(OP_STORE, KEY_ALIAS, 16'h0002);
    add_cmd(OP_PROBE, KEY_ONES, '0);
    add_cmd(OP_PROBE, KEY_ALIAS, 16'hffff);
    add_cmd(OP_STORE, '0, 16'h0000);
    add_cmd(OP_PROBE, 64'h400, '0);
    add_cmd(OP_PROBE, '0, '0);
    add_cmd(OP_STORE, 64'h8000_0000_0000_0000, 16'h0007);
    add_cmd(OP_PROBE, '0, '0);

    // random phases: a few entries shared by aliasing keys so hits, duplicates and
    // full entries come up, plus noise on fully random keys; later phases start
    // only once the block has delivered everything
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      for (int unsigned i = 0; i < 6; i++) pool_idx[i] = $urandom_range(0, TABLE_DEPTH - 1);
      for (int unsigned i = 0; i < 12; i++) begin
        k = {$urandom, $urandom};
        pool_key[i] = (k & ~KEY_W'(TABLE_DEPTH - 1)) | KEY_W'(pool_idx[i % 6]);
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          add_cmd(OP_STORE, pool_key[$urandom_range(0, 11)], pick_move(),
                  ph > 0 && i == 0);
        end else if (pick < 85) begin
          add_cmd(OP_PROBE, pool_key[$urandom_range(0, 11)], MOVE_IN_W'($urandom),
                  ph > 0 && i == 0);
        end else begin
          add_cmd(op_e'($urandom_range(0, 1)), {$urandom, $urandom},
                  MOVE_IN_W'($urandom), ph > 0 && i == 0);
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // settle on the falling edge so queue and start are stable when looked at
    do @(negedge clk_i); while (cmd_q.size() != 0 || start || due_q.size() != 0);
    repeat (SETTLE_TIME) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("** direct_mapped_move_book: PASSED **");
    end else begin
      $display("** direct_mapped_move_book: FAILED **");
    end
    $finish;
  end

endmodule
